### hdl/clqm_pkg.sv
// Types, codes and microcode table for the circular linked queue manager.
`default_nettype none

package clqm_pkg;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LINKED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    // Sequencer steps; BR_NEXT falls through to the following step.
    typedef enum logic [2:0] {
        UPC_IDLE      = 3'd0,
        UPC_DISPATCH  = 3'd1,
        UPC_APP_LINK  = 3'd2,
        UPC_APP_TAIL  = 3'd3,
        UPC_APP_FIRST = 3'd4,
        UPC_RM_FETCH  = 3'd5,
        UPC_RM_SPLICE = 3'd6,
        UPC_FINISH    = 3'd7
    } t_upc;

    typedef enum logic [1:0] {
        BR_WAIT     = 2'd0,
        BR_DISPATCH = 2'd1,
        BR_NEXT     = 2'd2,
        BR_END      = 2'd3
    } t_branch;

    typedef enum logic [1:0] {
        NXA_E = 2'd0,
        NXA_P = 2'd1
    } t_nx_wa;

    typedef enum logic [1:0] {
        NXD_HEAD = 2'd0,
        NXD_E    = 2'd1,
        NXD_N    = 2'd2
    } t_nx_wd;

    typedef enum logic [1:0] {
        PVA_E    = 2'd0,
        PVA_HEAD = 2'd1,
        PVA_N    = 2'd2
    } t_pv_wa;

    typedef enum logic [1:0] {
        PVD_E = 2'd0,
        PVD_P = 2'd1
    } t_pv_wd;

    typedef struct packed {
        t_branch br;
        logic    latch;
        logic    commit;
        logic    nx_we;
        t_nx_wa  nx_wa;
        t_nx_wd  nx_wd;
        logic    pv_we;
        t_pv_wa  pv_wa;
        t_pv_wd  pv_wd;
    } t_uword;

    function automatic t_uword ucode(input t_upc step);
        t_uword w;
        w = '{br: BR_END, latch: 1'b0, commit: 1'b0, nx_we: 1'b0, nx_wa: NXA_E,
              nx_wd: NXD_E, pv_we: 1'b0, pv_wa: PVA_E, pv_wd: PVD_E};
        unique case (step)
            UPC_IDLE: begin
                w.br = BR_WAIT;
            end
            UPC_DISPATCH: begin
                w.br = BR_DISPATCH;
            end
            UPC_APP_LINK: begin
                // tail arrives from prev[head]; new element points at head
                w.br    = BR_NEXT;
                w.latch = 1'b1;
                w.nx_we = 1'b1;
                w.nx_wa = NXA_E;
                w.nx_wd = NXD_HEAD;
                w.pv_we = 1'b1;
                w.pv_wa = PVA_HEAD;
                w.pv_wd = PVD_E;
            end
            UPC_APP_TAIL: begin
                w.commit = 1'b1;
                w.nx_we  = 1'b1;
                w.nx_wa  = NXA_P;
                w.nx_wd  = NXD_E;
                w.pv_we  = 1'b1;
                w.pv_wa  = PVA_E;
                w.pv_wd  = PVD_P;
            end
            UPC_APP_FIRST: begin
                w.commit = 1'b1;
                w.nx_we  = 1'b1;
                w.nx_wa  = NXA_E;
                w.nx_wd  = NXD_E;
                w.pv_we  = 1'b1;
                w.pv_wa  = PVA_E;
                w.pv_wd  = PVD_E;
            end
            UPC_RM_FETCH: begin
                w.br    = BR_NEXT;
                w.latch = 1'b1;
            end
            UPC_RM_SPLICE: begin
                w.commit = 1'b1;
                w.nx_we  = 1'b1;
                w.nx_wa  = NXA_P;
                w.nx_wd  = NXD_N;
                w.pv_we  = 1'b1;
                w.pv_wa  = PVA_N;
                w.pv_wd  = PVD_P;
            end
            UPC_FINISH: begin
                w.commit = 1'b1;
            end
            default: begin
                w.br = BR_END;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hdl/circular_linked_queue_manager_core.sv
// Top level of the circular linked queue manager: sequencer, link memories, result port.
`default_nettype none

// Circular doubly linked queue over NUM_SLOTS element slots.
// Command channel: an item (i_mode, i_elem_index) is taken at a rising edge
// with start high and busy low. Mode append links the slot in at the tail,
// just ahead of the head; mode remove unlinks the named slot.
// Result channel: o_valid pulses for one cycle with o_status, o_count,
// o_head_index and o_removed_index. The receiver cannot stall; a result
// that is not taken in its cycle is gone.
// Timing: the strobe rises at the edge that ends the last step. A failed
// or trivial item runs dispatch plus one step, a full link or unlink runs
// dispatch plus two steps, set by the single write port on each link
// memory and its registered read. busy drops in the strobe cycle, so a new
// item can be taken at the edge that ends it, but not while one is running.
// Reset: synchronous, active low. It clears the linked flags, the count,
// the head and the sequencer. The link memories are not cleared; a link is
// only read for a slot that is linked and has thus been written.
module circular_linked_queue_manager_core
    import clqm_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        i_mode,
    input  wire  [3:0] i_elem_index,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [4:0] o_count,
    output logic [3:0] o_head_index,
    output logic [3:0] o_removed_index
);

    localparam int SLOT_W = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [8:0] NUM_SLOTS_V = 9'(NUM_SLOTS);

    // sequencer and datapath registers
    t_upc              r_upc, n_upc;
    t_status           r_status, n_status;
    logic              r_mode;
    logic [3:0]        r_e;
    logic [SLOT_W-1:0] r_p, r_n;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [NUM_SLOTS-1:0] r_linked, n_linked;

    // link memories with registered reads
    logic [SLOT_W-1:0] r_next_mem [NUM_SLOTS];
    logic [SLOT_W-1:0] r_prev_mem [NUM_SLOTS];
    logic [SLOT_W-1:0] r_next_rd, r_prev_rd;

    t_uword            uw;
    logic [SLOT_W-1:0] slot;
    logic              in_range;
    logic              accept;
    logic [SLOT_W-1:0] prev_ra;
    logic [SLOT_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
    logic              ok_commit;

    assign slot     = SLOT_W'(r_e);
    assign in_range = {5'd0, r_e} < NUM_SLOTS_V;
    assign busy     = (r_upc != UPC_IDLE);
    assign accept   = start && !busy;
    assign uw       = ucode(r_upc);

    // append reads prev[head] to find the tail; remove reads both links of the slot
    assign prev_ra  = (r_mode == MODE_REMOVE) ? slot : r_head;

    always_ff @(posedge i_clk) begin
        r_next_rd <= r_next_mem[slot];
        r_prev_rd <= r_prev_mem[prev_ra];
        if (uw.nx_we) begin
            r_next_mem[nx_wa] <= nx_wd;
        end
        if (uw.pv_we) begin
            r_prev_mem[pv_wa] <= pv_wd;
        end
    end

    // write address and data selection from the control word
    always_comb begin
        case (uw.nx_wa)
            NXA_P:   nx_wa = r_p;
            default: nx_wa = slot;
        endcase
        case (uw.nx_wd)
            NXD_HEAD: nx_wd = r_head;
            NXD_N:    nx_wd = r_n;
            default:  nx_wd = slot;
        endcase
        case (uw.pv_wa)
            PVA_HEAD: pv_wa = r_head;
            PVA_N:    pv_wa = r_n;
            default:  pv_wa = slot;
        endcase
        case (uw.pv_wd)
            PVD_P:   pv_wd = r_p;
            default: pv_wd = slot;
        endcase
    end

    // step counter, dispatch checks and queue state update
    always_comb begin
        n_upc    = r_upc;
        n_status = r_status;
        unique case (uw.br)
            BR_WAIT: begin
                if (accept) begin
                    n_upc = UPC_DISPATCH;
                end
            end
            BR_DISPATCH: begin
                n_status = ST_OK;
                n_upc    = UPC_FINISH;
                if (r_mode == MODE_APPEND) begin
                    if (!in_range) begin
                        n_status = ST_ABSENT;
                    end else if (r_linked[slot]) begin
                        n_status = ST_LINKED;
                    end else if (r_count == '0) begin
                        n_upc = UPC_APP_FIRST;
                    end else begin
                        n_upc = UPC_APP_LINK;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (!in_range || !r_linked[slot]) begin
                        n_status = ST_ABSENT;
                    end else if (r_count != CNT_W'(1)) begin
                        n_upc = UPC_RM_FETCH;
                    end
                end
            end
            BR_NEXT: begin
                n_upc = t_upc'(r_upc + 3'd1);
            end
            BR_END: begin
                n_upc = UPC_IDLE;
            end
            default: begin
                n_upc = UPC_IDLE;
            end
        endcase

        ok_commit = uw.commit && (r_status == ST_OK);
        n_count   = r_count;
        n_head    = r_head;
        n_linked  = r_linked;
        if (ok_commit) begin
            if (r_mode == MODE_APPEND) begin
                n_linked[slot] = 1'b1;
                n_count        = r_count + CNT_W'(1);
                if (r_count == '0) begin
                    n_head = slot;
                end
            end else begin
                n_linked[slot] = 1'b0;
                n_count        = r_count - CNT_W'(1);
                // last element leaves: empty queue parks the head at zero
                if (r_count == CNT_W'(1)) begin
                    n_head = '0;
                end else if (r_head == slot) begin
                    n_head = r_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc    <= UPC_IDLE;
            r_status <= ST_OK;
            r_count  <= '0;
            r_head   <= '0;
            r_linked <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_upc    <= n_upc;
            r_status <= n_status;
            r_count  <= n_count;
            r_head   <= n_head;
            r_linked <= n_linked;
            o_valid  <= uw.commit;
        end
    end

    // item capture, link latch and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_e    <= i_elem_index;
        end
        if (uw.latch) begin
            r_p <= r_prev_rd;
            r_n <= r_next_rd;
        end
        if (uw.commit) begin
            o_status        <= r_status;
            o_count         <= 5'(n_count);
            o_head_index    <= (n_count != '0) ? 4'(n_head) : 4'd0;
            o_removed_index <= (ok_commit && r_mode == MODE_REMOVE) ? r_e : 4'd0;
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer still running");

    a_flag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_linked) == int'(r_count))
        else $error("linked flags disagree with element count");

    a_refused_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_removed_index == 4'd0))
        else $error("refused item reports a removed slot");
`endif

endmodule

`default_nettype wire
